/* rtl/tlbpf_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpf_pkg
// Shared types and codes for the page fault and frame manager: request and
// response words, operation and access codes, and frame bitmap commands.
// ----------------------------------------------------------------------------
package tlbpf_pkg;

   localparam int FRAME_COUNT_DEF = 128;
   localparam int PAGE_COUNT_DEF  = 256;

   localparam int OP_W        = 2;
   localparam int PAGE_W      = 8;
   localparam int ACC_W       = 2;
   localparam int FRAME_NUM_W = 7;

   localparam int ROW_W     = 64;
   localparam int ROW_BIT_W = 6;

   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
   localparam logic [OP_W-1:0] OP_FAULT     = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE      = 2'd2;

   localparam logic [ACC_W-1:0] ACC_NONE  = 2'd0;
   localparam logic [ACC_W-1:0] ACC_WRITE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [PAGE_W-1:0] page_number;
      logic [ACC_W-1:0]  access_code;
   } req_type;

   typedef struct packed {
      logic                   success;
      logic [FRAME_NUM_W-1:0] frame_number;
   } rsp_type;

   typedef struct packed {
      logic scan;
      logic commit;
      logic rel_rd;
      logic rel_wr;
   } bm_cmd_type;

endpackage

/* rtl/tlbpf_page_map.sv */
// ----------------------------------------------------------------------------
// tlbpf_page_map
// Page-indexed mapping memory holding valid, frame and access for each page.
// One registered read port and one write port; clears itself after reset.
// ----------------------------------------------------------------------------
module tlbpf_page_map #(
   parameter int PAGE_COUNT  = tlbpf_pkg::PAGE_COUNT_DEF,
   parameter int FRAME_COUNT = tlbpf_pkg::FRAME_COUNT_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        rd_en,
   input  logic [$clog2(PAGE_COUNT)-1:0]               rd_addr,
   output logic                                        rd_valid,
   output logic [$clog2(FRAME_COUNT)-1:0]              rd_frame,
   output logic [tlbpf_pkg::ACC_W-1:0]                 rd_access,
   input  logic                                        wr_en,
   input  logic [$clog2(PAGE_COUNT)-1:0]               wr_addr,
   input  logic                                        wr_valid,
   input  logic [$clog2(FRAME_COUNT)-1:0]              wr_frame,
   input  logic [tlbpf_pkg::ACC_W-1:0]                 wr_access,
   output logic                                        busy
);
   import tlbpf_pkg::*;

   localparam int AW    = $clog2(PAGE_COUNT);
   localparam int FW    = $clog2(FRAME_COUNT);
   localparam int DW    = 1 + FW + ACC_W;
   localparam int CLR_W = $clog2(PAGE_COUNT + 1);

   logic [DW-1:0]    mem_ff [PAGE_COUNT];
   logic [DW-1:0]    rd_ff;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;

   assign busy = (clr_cnt_ff != CLR_W'(PAGE_COUNT));

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (busy) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem_ff[clr_cnt_ff[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_addr] <= {wr_valid, wr_frame, wr_access};
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_valid  = rd_ff[DW-1];
   assign rd_frame  = rd_ff[DW-2:ACC_W];
   assign rd_access = rd_ff[ACC_W-1:0];

endmodule

/* rtl/tlbpf_frame_bitmap.sv */
// ----------------------------------------------------------------------------
// tlbpf_frame_bitmap
// Frame in-use map stored as 64-bit rows in a memory, with a per-row full
// flag that steers the search for the lowest free frame.
// ----------------------------------------------------------------------------
module tlbpf_frame_bitmap #(
   parameter int FRAME_COUNT = tlbpf_pkg::FRAME_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tlbpf_pkg::bm_cmd_type          cmd,
   input  logic [$clog2(FRAME_COUNT)-1:0] rel_frame,
   output logic                           found,
   output logic [$clog2(FRAME_COUNT)-1:0] alloc_frame,
   output logic                           busy
);
   import tlbpf_pkg::*;

   localparam int ROWS      = (FRAME_COUNT + ROW_W - 1) / ROW_W;
   localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FW        = $clog2(FRAME_COUNT);
   localparam int WIDE_W    = ROW_IDX_W + ROW_BIT_W;
   localparam int LAST_BITS = FRAME_COUNT - (ROWS - 1) * ROW_W;
   localparam int CLR_W     = $clog2(ROWS + 1);

   function automatic logic [ROW_W-1:0] lowest_hot(input logic [ROW_W-1:0] v);
      return v & (~v + 1'b1);
   endfunction

   function automatic logic [ROW_BIT_W-1:0] lowest_index(input logic [ROW_W-1:0] v);
      logic [ROW_W-1:0]     hot;
      logic [ROW_BIT_W-1:0] idx;
      hot = lowest_hot(v);
      idx = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (hot[i]) begin
            idx = idx | ROW_BIT_W'(i);
         end
      end
      return idx;
   endfunction

   logic [ROW_W-1:0]     mem_ff [ROWS];
   logic [ROW_W-1:0]     rd_data_ff;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic [ROW_BIT_W-1:0] rel_bit_ff, rel_bit_in;
   logic                 any_free_ff, any_free_in;
   logic [ROWS-1:0]      full_ff, full_in;
   logic [CLR_W-1:0]     clr_cnt_ff, clr_cnt_in;

   logic [ROW_W-1:0]     free_rows;
   logic [ROW_IDX_W-1:0] scan_row;
   logic [ROW_W-1:0]     last_mask;
   logic [ROW_W-1:0]     row_mask;
   logic [ROW_W-1:0]     avail;
   logic [ROW_W-1:0]     pick_hot;
   logic [ROW_BIT_W-1:0] pick_bit;
   logic [ROW_W-1:0]     set_data;
   logic [ROW_W-1:0]     clr_data;
   logic [WIDE_W-1:0]    rel_wide;
   logic [ROW_IDX_W-1:0] rel_row;

   assign busy      = (clr_cnt_ff != CLR_W'(ROWS));
   assign free_rows = ROW_W'(~full_ff);
   assign scan_row  = ROW_IDX_W'(lowest_index(free_rows));

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         last_mask[i] = (i < LAST_BITS);
      end
   end

   assign row_mask    = (row_ff == ROW_IDX_W'(ROWS - 1)) ? last_mask : '1;
   assign avail       = ~rd_data_ff & row_mask;
   assign pick_hot    = lowest_hot(avail);
   assign pick_bit    = lowest_index(avail);
   assign set_data    = rd_data_ff | pick_hot;
   assign clr_data    = rd_data_ff & ~(ROW_W'(1) << rel_bit_ff);
   assign found       = any_free_ff;
   assign alloc_frame = FW'({row_ff, pick_bit});

   assign rel_wide = WIDE_W'(rel_frame);
   assign rel_row  = rel_wide[WIDE_W-1:ROW_BIT_W];

   always_comb begin
      row_in      = row_ff;
      rel_bit_in  = rel_bit_ff;
      any_free_in = any_free_ff;
      full_in     = full_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (busy) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (cmd.scan) begin
         row_in      = scan_row;
         any_free_in = ~&full_ff;
      end else if (cmd.rel_rd) begin
         row_in     = rel_row;
         rel_bit_in = rel_wide[ROW_BIT_W-1:0];
      end
      if (cmd.commit) begin
         full_in[row_ff] = &(set_data | ~row_mask);
      end else if (cmd.rel_wr) begin
         full_in[row_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         full_ff     <= '0;
         any_free_ff <= 1'b0;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         full_ff     <= full_in;
         any_free_ff <= any_free_in;
      end
      row_ff     <= row_in;
      rel_bit_ff <= rel_bit_in;
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         mem_ff[clr_cnt_ff[ROW_IDX_W-1:0]] <= '0;
      end else if (cmd.commit) begin
         mem_ff[row_ff] <= set_data;
      end else if (cmd.rel_wr) begin
         mem_ff[row_ff] <= clr_data;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem_ff[scan_row];
      end else if (cmd.rel_rd) begin
         rd_data_ff <= mem_ff[rel_row];
      end
   end

endmodule

/* rtl/tlb_page_fault_frame_manager.sv */
// ----------------------------------------------------------------------------
// tlb_page_fault_frame_manager
// A translate or fault word passes S_LOOK and S_OUT before rsp_valid rises, a
// free of a mapped page S_LOOK, S_FREE_WR and S_OUT; the next word is taken in
// S_IDLE, and a held response keeps the word after it in the output stage.
// After reset the page map clears its PAGE_COUNT entries and the bitmap its
// ceil(FRAME_COUNT/64) rows in parallel; requests stall until both finish.
// ----------------------------------------------------------------------------
module tlb_page_fault_frame_manager #(
   parameter int FRAME_COUNT = tlbpf_pkg::FRAME_COUNT_DEF,
   parameter int PAGE_COUNT  = tlbpf_pkg::PAGE_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlbpf_pkg::req_type req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlbpf_pkg::rsp_type rsp_word
);
   import tlbpf_pkg::*;

   localparam int MAP_AW = $clog2(PAGE_COUNT);
   localparam int FW     = $clog2(FRAME_COUNT);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_LOOK    = 3'd1;
   localparam logic [2:0] S_FREE_WR = 3'd2;
   localparam logic [2:0] S_OUT     = 3'd3;

   logic [2:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   logic        in_range_ff, in_range_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic              load;
   logic              in_range;
   logic              map_rd_en;
   logic              map_rd_valid;
   logic [FW-1:0]     map_rd_frame;
   logic [ACC_W-1:0]  map_rd_access;
   logic              map_wr_en;
   logic              map_wr_valid;
   logic [FW-1:0]     map_wr_frame;
   logic [ACC_W-1:0]  map_wr_access;
   logic              map_busy;
   bm_cmd_type        bm_cmd;
   logic              bm_found;
   logic [FW-1:0]     bm_frame;
   logic              bm_busy;
   logic              mapped;
   logic              need_frame;

   assign req_stall = (state_ff != S_IDLE) || map_busy || bm_busy;
   assign accept    = req_valid && !req_stall;
   assign load      = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign in_range  = (32'(req_word.page_number) < PAGE_COUNT);
   assign map_rd_en = accept && in_range;

   assign mapped     = in_range_ff && map_rd_valid;
   assign need_frame = in_range_ff && (!map_rd_valid ||
                       (req_ff.access_code == ACC_WRITE && map_rd_access == ACC_NONE));

   tlbpf_page_map #(
      .PAGE_COUNT  (PAGE_COUNT),
      .FRAME_COUNT (FRAME_COUNT)
   ) u_map (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (map_rd_en),
      .rd_addr   (MAP_AW'(req_word.page_number)),
      .rd_valid  (map_rd_valid),
      .rd_frame  (map_rd_frame),
      .rd_access (map_rd_access),
      .wr_en     (map_wr_en),
      .wr_addr   (MAP_AW'(req_ff.page_number)),
      .wr_valid  (map_wr_valid),
      .wr_frame  (map_wr_frame),
      .wr_access (map_wr_access),
      .busy      (map_busy)
   );

   tlbpf_frame_bitmap #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_bitmap (
      .clock       (clock),
      .reset       (reset),
      .cmd         (bm_cmd),
      .rel_frame   (map_rd_frame),
      .found       (bm_found),
      .alloc_frame (bm_frame),
      .busy        (bm_busy)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      in_range_in   = in_range_ff;
      res_in        = res_ff;
      map_wr_en     = 1'b0;
      map_wr_valid  = 1'b0;
      map_wr_frame  = '0;
      map_wr_access = ACC_NONE;
      bm_cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in      = req_word;
               in_range_in = in_range;
               bm_cmd.scan = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            res_in   = '0;
            state_in = S_OUT;
            unique case (req_ff.operation)
               OP_TRANSLATE: begin
                  if (mapped && map_rd_access == req_ff.access_code) begin
                     res_in.success      = 1'b1;
                     res_in.frame_number = FRAME_NUM_W'(map_rd_frame);
                  end
               end
               OP_FAULT: begin
                  if (need_frame && bm_found) begin
                     bm_cmd.commit       = 1'b1;
                     map_wr_en           = 1'b1;
                     map_wr_valid        = 1'b1;
                     map_wr_frame        = bm_frame;
                     map_wr_access       = map_rd_valid ? ACC_WRITE : req_ff.access_code;
                     res_in.success      = 1'b1;
                     res_in.frame_number = FRAME_NUM_W'(bm_frame);
                  end
               end
               OP_FREE: begin
                  res_in.success = 1'b1;
                  if (mapped) begin
                     map_wr_en     = 1'b1;
                     bm_cmd.rel_rd = 1'b1;
                     state_in      = S_FREE_WR;
                  end
               end
               default: begin
               end
            endcase
         end
         S_FREE_WR: begin
            bm_cmd.rel_wr = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load;
      rsp_in       = load ? res_ff : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      in_range_ff <= in_range_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (map_busy || bm_busy) |-> !(req_valid && !req_stall))
      else $error("request accepted during memory clearing");

   a_commit_needs_free_frame: assert property (@(posedge clock) disable iff (reset)
      bm_cmd.commit |-> bm_found)
      else $error("frame committed with no free frame");

   a_release_follows_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE_WR) |-> ($past(state_ff) == S_LOOK))
      else $error("frame release write without lookup");

   a_rsp_from_out_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside output state");

endmodule
